// ===== sv/ufct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufct_pkg
// Shared types, codes and helpers for the UART receive FIFO and timing block.
// ----------------------------------------------------------------------------
package ufct_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_RX    = 2'd3
    } op_t;

    localparam logic [2:0]  ADDR_DATA     = 3'd3;
    localparam logic [2:0]  ADDR_STATUS   = 3'd5;

    localparam logic [7:0]  ST_TXRDY      = 8'h01;
    localparam logic [7:0]  ST_RXRDY      = 8'h04;
    localparam logic [7:0]  RD_UNMAPPED   = 8'hFF;
    localparam logic [15:0] CHAR_TIME_RST = 16'd65;

    // FIFO status seen by the control logic
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    // saturating countdown
    function automatic logic [15:0] count_down(input logic [15:0] t,
                                               input logic [15:0] dt);
        logic [15:0] res;
        res = (dt >= t) ? 16'd0 : (t - dt);
        return res;
    endfunction

endpackage

// ===== sv/ufct_rx_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufct_rx_fifo
// Receive FIFO: synchronous memory with registered read data and
// pointers that wrap at twice the depth.
// ----------------------------------------------------------------------------
module ufct_rx_fifo #(
    parameter int DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            push_data,
    input  logic                  pop,
    output ufct_pkg::fifo_stat_t  stat,
    output logic [7:0]            pop_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W = IDX_W + 1;
    localparam int LVL_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(2 * DEPTH - 1);
    localparam logic [LVL_W-1:0] SPAN_L  = LVL_W'(2 * DEPTH);
    localparam logic [LVL_W-1:0] DEPTH_L = LVL_W'(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_off, rd_off;
    logic [IDX_W-1:0] wr_idx, rd_idx;
    logic [LVL_W-1:0] level;

    always_comb
    begin
        wr_off = (wr_ptr_reg >= DEPTH_P) ? (wr_ptr_reg - DEPTH_P) : wr_ptr_reg;
        rd_off = (rd_ptr_reg >= DEPTH_P) ? (rd_ptr_reg - DEPTH_P) : rd_ptr_reg;
        wr_idx = wr_off[IDX_W-1:0];
        rd_idx = rd_off[IDX_W-1:0];

        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            level = LVL_W'(wr_ptr_reg) - LVL_W'(rd_ptr_reg);
        end
        else
        begin
            level = LVL_W'(wr_ptr_reg) + SPAN_L - LVL_W'(rd_ptr_reg);
        end

        stat.empty = (wr_ptr_reg == rd_ptr_reg);
        stat.full  = (level >= DEPTH_L);

        wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : (wr_ptr_reg + 1'b1);
        rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : (rd_ptr_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_idx] <= push_data;
        end
    end

    // read data holds until the next pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pop_data <= mem[rd_idx];
        end
    end

endmodule

// ===== sv/uart_fifo_char_timing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_fifo_char_timing
// UART register model with a receive FIFO and character timers.
// ----------------------------------------------------------------------------
// The result is registered at the edge that accepts its request and is offered
// from the next cycle on.
// Throughput: one request per cycle; a result the receiver has not taken
// holds s_axis_tready low until it leaves.
// Reset (rst_n low, asynchronous): transmit-ready set, mask and timers clear,
// FIFO empty, character time 65 us. No clearing pass is needed.
module uart_fifo_char_timing #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: character time in microseconds
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [2:0] reg_addr, [10:3] data_byte,
                                       // [26:11] elapsed_us, [31:27] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] operation
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // [7:0] read_data, [8] irq_active,
                                       // [9] tx_valid, [17:10] tx_byte,
                                       // [18] rx_dropped, [23:19] zero
);

    ufct_pkg::op_t        op;
    logic [2:0]           reg_addr;
    logic [7:0]           data_byte;
    logic [15:0]          elapsed_us;
    logic                 in_accept;

    logic [15:0]          char_time_reg;
    logic [7:0]           status_reg, status_next;
    logic [7:0]           mask_reg, mask_next;
    logic [15:0]          tx_cnt_reg, tx_cnt_next;
    logic [15:0]          rx_cnt_reg, rx_cnt_next;
    logic                 held_vld_reg, held_vld_next;
    logic                 out_vld_reg;
    logic [23:0]          out_data_reg, out_data_next;

    logic [7:0]           held_byte;
    logic [7:0]           fifo_rd_data;
    ufct_pkg::fifo_stat_t fifo_stat;
    logic                 push, pop;
    logic [15:0]          tx_dec, rx_dec;

    logic [7:0]           rd_data;
    logic                 irq;
    logic                 tx_vld;
    logic [7:0]           tx_byte;
    logic                 dropped;

    assign op         = ufct_pkg::op_t'(s_axis_tuser);
    assign reg_addr   = s_axis_tdata[2:0];
    assign data_byte  = s_axis_tdata[10:3];
    assign elapsed_us = s_axis_tdata[26:11];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_vld_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // data register reads zero until the first byte is popped
    assign held_byte = held_vld_reg ? fifo_rd_data : 8'h00;

    ufct_rx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (data_byte),
        .pop       (pop),
        .stat      (fifo_stat),
        .pop_data  (fifo_rd_data)
    );

    always_comb
    begin
        status_next   = status_reg;
        mask_next     = mask_reg;
        tx_cnt_next   = tx_cnt_reg;
        rx_cnt_next   = rx_cnt_reg;
        held_vld_next = held_vld_reg;
        push          = 1'b0;
        pop           = 1'b0;
        rd_data       = ufct_pkg::RD_UNMAPPED;
        tx_vld        = 1'b0;
        tx_byte       = 8'h00;
        dropped       = 1'b0;
        tx_dec        = ufct_pkg::count_down(tx_cnt_reg, elapsed_us);
        rx_dec        = ufct_pkg::count_down(rx_cnt_reg, elapsed_us);

        unique case (op)
            ufct_pkg::OP_READ:
            begin
                unique case (reg_addr)
                    ufct_pkg::ADDR_DATA:
                    begin
                        rd_data     = held_byte;
                        status_next = status_reg & ~ufct_pkg::ST_RXRDY;
                    end
                    ufct_pkg::ADDR_STATUS:
                    begin
                        rd_data = status_reg;
                    end
                    default:
                    begin
                        rd_data = ufct_pkg::RD_UNMAPPED;
                    end
                endcase
            end
            ufct_pkg::OP_WRITE:
            begin
                unique case (reg_addr)
                    ufct_pkg::ADDR_DATA:
                    begin
                        tx_vld      = 1'b1;
                        tx_byte     = data_byte;
                        tx_cnt_next = char_time_reg;
                        status_next = status_reg & ~ufct_pkg::ST_TXRDY;
                    end
                    ufct_pkg::ADDR_STATUS:
                    begin
                        mask_next = data_byte;
                    end
                    default:
                    begin
                        mask_next = mask_reg;
                    end
                endcase
            end
            ufct_pkg::OP_TICK:
            begin
                if (tx_cnt_reg != 16'd0)
                begin
                    tx_cnt_next = tx_dec;
                    if (tx_dec == 16'd0)
                    begin
                        status_next = status_next | ufct_pkg::ST_TXRDY;
                    end
                end
                rx_cnt_next = rx_dec;
                // receive timer idle: move the next FIFO byte to the data register
                if (rx_dec == 16'd0 && !fifo_stat.empty)
                begin
                    pop           = 1'b1;
                    held_vld_next = 1'b1;
                    status_next   = status_next | ufct_pkg::ST_RXRDY;
                    rx_cnt_next   = char_time_reg;
                end
            end
            ufct_pkg::OP_RX:
            begin
                if (fifo_stat.full)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            default:
            begin
                rd_data = ufct_pkg::RD_UNMAPPED;
            end
        endcase

        // FIFO moves only on an accepted request
        push = push && in_accept;
        pop  = pop && in_accept;

        irq           = ((status_next & mask_next) != 8'h00);
        out_data_next = {5'b0, dropped, tx_byte, tx_vld, irq, rd_data};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_time_reg <= ufct_pkg::CHAR_TIME_RST;
            status_reg    <= ufct_pkg::ST_TXRDY;
            mask_reg      <= 8'h00;
            tx_cnt_reg    <= 16'd0;
            rx_cnt_reg    <= 16'd0;
            held_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                char_time_reg <= cfg_data;
            end
            if (in_accept)
            begin
                status_reg   <= status_next;
                mask_reg     <= mask_next;
                tx_cnt_reg   <= tx_cnt_next;
                rx_cnt_reg   <= rx_cnt_next;
                held_vld_reg <= held_vld_next;
                out_vld_reg  <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && fifo_stat.full))
        else $error("push into full receive FIFO");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && fifo_stat.empty))
        else $error("pop from empty receive FIFO");

    a_pop_sets_rxrdy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (held_vld_reg && ((status_reg & ufct_pkg::ST_RXRDY) != 8'h00)))
        else $error("popped byte without receive-ready");

    a_tx_clears_txrdy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && out_data_next[9]) |=>
            (m_axis_tvalid && ((status_reg & ufct_pkg::ST_TXRDY) == 8'h00)))
        else $error("transmit left transmit-ready set");
`endif

endmodule

// ===== tb/tb_uart_fifo_char_timing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_fifo_char_timing
// Self-checking bench for the UART register block with receive FIFO. A shadow
// model in a scoreboard class tracks status, mask, timers and FIFO contents,
// predicts one result per accepted request and compares it field by field.
// A directed sequence comes first. Randomized phases follow, each with its
// own character time; some add sender gaps, receiver stalls or both.
// ----------------------------------------------------------------------------
module tb_uart_fifo_char_timing;

    import ufct_pkg::*;

    localparam int          FIFO_SLOTS    = 256;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          REPORT_MAX    = 10;
    localparam logic [2:0]  ADDR_NONE_LO  = 3'd0;
    localparam logic [2:0]  ADDR_NONE_HI  = 3'd7;

    // result fields, lowest bit last
    typedef struct packed {
        logic [4:0] pad;
        logic       rx_dropped;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       irq_active;
        logic [7:0] read_data;
    } uart_result_t;

    class uart_char_model;
        logic [15:0]  char_time;
        logic [7:0]   status;
        logic [7:0]   mask;
        logic [7:0]   held_byte;
        logic [15:0]  tx_left;
        logic [15:0]  rx_left;
        logic [7:0]   rx_store [FIFO_SLOTS];
        logic [8:0]   rd_ptr;
        logic [8:0]   wr_ptr;
        uart_result_t expected_results [$];
        int           requests;
        int           checked;
        int           mismatches;
        int           sent_bytes;
        int           popped_bytes;
        int           dropped_bytes;

        function new();
            char_time     = CHAR_TIME_RST;
            status        = ST_TXRDY;
            mask          = 8'h00;
            held_byte     = 8'h00;
            tx_left       = 16'd0;
            rx_left       = 16'd0;
            rd_ptr        = 9'd0;
            wr_ptr        = 9'd0;
            requests      = 0;
            checked       = 0;
            mismatches    = 0;
            sent_bytes    = 0;
            popped_bytes  = 0;
            dropped_bytes = 0;
        endfunction

        function void accept_request(input op_t op, input logic [2:0] addr,
                                     input logic [7:0] data, input logic [15:0] dt);
            uart_result_t r;
            logic [8:0]   level;
            r           = '0;
            r.read_data = RD_UNMAPPED;
            level       = wr_ptr - rd_ptr;
            case (op)
                OP_READ:
                begin
                    if (addr == ADDR_DATA)
                    begin
                        r.read_data = held_byte;
                        status &= ~ST_RXRDY;
                    end
                    else if (addr == ADDR_STATUS)
                        r.read_data = status;
                end
                OP_WRITE:
                begin
                    if (addr == ADDR_DATA)
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = data;
                        tx_left    = char_time;
                        status &= ~ST_TXRDY;
                        sent_bytes++;
                    end
                    else if (addr == ADDR_STATUS)
                        mask = data;
                end
                OP_TICK:
                begin
                    // a timer already at zero neither moves nor raises a flag
                    if (tx_left != 16'd0)
                    begin
                        tx_left = (dt >= tx_left) ? 16'd0 : tx_left - dt;
                        if (tx_left == 16'd0)
                            status |= ST_TXRDY;
                    end
                    if (rx_left != 16'd0)
                        rx_left = (dt >= rx_left) ? 16'd0 : rx_left - dt;
                    // pop at most one byte per tick
                    if (rx_left == 16'd0 && level != 9'd0)
                    begin
                        held_byte = rx_store[rd_ptr[7:0]];
                        rd_ptr    = rd_ptr + 9'd1;
                        status |= ST_RXRDY;
                        rx_left   = char_time;
                        popped_bytes++;
                    end
                end
                default:
                begin
                    if (level >= FIFO_SLOTS)
                    begin
                        r.rx_dropped = 1'b1;
                        dropped_bytes++;
                    end
                    else
                    begin
                        rx_store[wr_ptr[7:0]] = data;
                        wr_ptr = wr_ptr + 9'd1;
                    end
                end
            endcase
            r.irq_active = |(status & mask);
            expected_results.push_back(r);
            requests++;
        endfunction

        function void check_result(input logic [23:0] tdata);
            uart_result_t got;
            uart_result_t want;
            got = uart_result_t'(tdata);
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result %h with nothing pending", tdata);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.read_data !== want.read_data || got.irq_active !== want.irq_active ||
                got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                got.rx_dropped !== want.rx_dropped)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d: expected rd=%h irq=%b txv=%b txb=%h drop=%b, got rd=%h irq=%b txv=%b txb=%h drop=%b",
                             checked, want.read_data, want.irq_active, want.tx_valid,
                             want.tx_byte, want.rx_dropped, got.read_data, got.irq_active,
                             got.tx_valid, got.tx_byte, got.rx_dropped);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data       = 16'd0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata   = 32'd0;
    logic [1:0]  s_axis_tuser   = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [23:0] m_axis_tdata;

    uart_char_model sb = new();
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int cycles         = 0;
    logic [15:0] ct_mid;
    logic [15:0] ct_low;

    uart_fifo_char_timing #(
        .FIFO_DEPTH(FIFO_SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, sb.expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(input op_t op, input logic [2:0] addr,
                                input logic [7:0] data, input logic [15:0] dt,
                                input bit hold_off);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0 || hold_off)
        begin
            s_axis_tvalid <= 1'b0;
            // drain every pending result before the next request
            if (hold_off)
                do @(posedge clk); while (sb.expected_results.size() != 0);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, dt, data, addr};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        sb.accept_request(op, addr, data, dt);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_char_time(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        sb.char_time = value;
    endtask

    function automatic op_t pick_op(input int w_rd, input int w_wr, input int w_tk);
        int r;
        r = $urandom_range(99);
        if (r < w_rd)
            return OP_READ;
        else if (r < w_rd + w_wr)
            return OP_WRITE;
        else if (r < w_rd + w_wr + w_tk)
            return OP_TICK;
        return OP_RX;
    endfunction

    function automatic logic [2:0] pick_addr();
        if ($urandom_range(9) < 7)
            return $urandom_range(1) ? ADDR_DATA : ADDR_STATUS;
        return 3'($urandom_range(7));
    endfunction

    // bias tick lengths toward the character time so timers expire on the edge
    function automatic logic [15:0] pick_elapsed();
        logic [15:0] ct;
        ct = sb.char_time;
        case ($urandom_range(9))
            0, 1:    return 16'($urandom_range(3));
            2, 3, 4: return 16'(ct + 16'($urandom_range(2)) - 16'd1);
            5:       return 16'hFFFF;
            6:       return ct >> $urandom_range(1, 3);
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic run_phase(input int count, input int w_rd, input int w_wr,
                             input int w_tk, input bit pressure);
        op_t op;
        for (int i = 0; i < count; i++)
        begin
            op = pick_op(w_rd, w_wr, w_tk);
            send_request(op, pick_addr(), 8'($urandom_range(255)), pick_elapsed(),
                         pressure && (i % 40 == 39));
        end
        settle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass at the reset character time
        send_request(OP_READ,  ADDR_STATUS,  8'h00, 16'h0000, 1'b0);
        send_request(OP_READ,  ADDR_DATA,    8'h00, 16'h0000, 1'b0);
        send_request(OP_READ,  ADDR_NONE_LO, 8'h00, 16'h0000, 1'b0);
        send_request(OP_READ,  ADDR_NONE_HI, 8'hFF, 16'hFFFF, 1'b0);
        send_request(OP_WRITE, ADDR_STATUS,  8'hFF, 16'h0000, 1'b0);
        send_request(OP_WRITE, ADDR_NONE_HI, 8'hAA, 16'h0000, 1'b0);
        send_request(OP_TICK,  ADDR_NONE_LO, 8'h00, 16'h0000, 1'b0);
        send_request(OP_WRITE, ADDR_DATA,    8'h00, 16'h0000, 1'b0);
        send_request(OP_WRITE, ADDR_DATA,    8'hFF, 16'hFFFF, 1'b0);
        send_request(OP_TICK,  ADDR_NONE_LO, 8'h00, 16'd10,   1'b0);
        send_request(OP_TICK,  ADDR_NONE_LO, 8'h00, 16'hFFFF, 1'b0);
        send_request(OP_RX,    ADDR_NONE_LO, 8'hA5, 16'h0000, 1'b0);
        send_request(OP_RX,    ADDR_NONE_HI, 8'h5A, 16'h0000, 1'b0);
        send_request(OP_TICK,  ADDR_NONE_LO, 8'h00, 16'h0000, 1'b0);
        send_request(OP_READ,  ADDR_STATUS,  8'h00, 16'h0000, 1'b0);
        send_request(OP_TICK,  ADDR_NONE_LO, 8'h00, 16'd64,   1'b0);
        send_request(OP_TICK,  ADDR_NONE_LO, 8'h00, 16'd1,    1'b0);
        send_request(OP_READ,  ADDR_DATA,    8'h00, 16'h0000, 1'b0);
        send_request(OP_READ,  ADDR_DATA,    8'h00, 16'h0000, 1'b0);
        send_request(OP_WRITE, ADDR_STATUS,  8'h00, 16'h0000, 1'b0);
        send_request(OP_WRITE, ADDR_STATUS,  ST_RXRDY, 16'h0000, 1'b0);
        send_request(OP_TICK,  ADDR_NONE_LO, 8'h00, 16'hFFFF, 1'b0);
        send_request(OP_RX,    ADDR_NONE_LO, 8'hFF, 16'h0000, 1'b0);
        send_request(OP_TICK,  ADDR_NONE_HI, 8'h00, 16'hFFFF, 1'b0);
        settle();

        // slow characters and mostly received bytes: overflow the FIFO
        write_char_time(16'hFFFF);
        run_phase(330, 5, 5, 5, 1'b0);

        // fastest characters, sender mostly idle: drain with ticks
        send_idle_pct = 80;
        write_char_time(16'd1);
        run_phase(110, 30, 15, 45, 1'b0);

        send_idle_pct = 0;
        stall_pct     = 80;
        ct_mid        = 16'($urandom_range(1, 65535));
        write_char_time(ct_mid);
        run_phase(100, 25, 25, 25, 1'b1);

        send_idle_pct = 32;
        stall_pct     = 32;
        ct_low        = 16'($urandom_range(2, 300));
        write_char_time(ct_low);
        run_phase(80, 25, 25, 30, 1'b1);

        // zero character time: transmit-ready never returns after a send
        send_idle_pct = 0;
        stall_pct     = 0;
        write_char_time(16'd0);
        run_phase(30, 25, 30, 30, 1'b0);

        $display("Covered %0d requests, %0d results checked: %0d bytes sent, %0d popped, %0d dropped on a full FIFO",
                 sb.requests, sb.checked, sb.sent_bytes, sb.popped_bytes, sb.dropped_bytes);
        $display("Character times 65, 65535, 1, %0d, %0d and 0; %0d mismatches",
                 ct_mid, ct_low, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ufct_pkg.sv
sv/ufct_rx_fifo.sv
sv/uart_fifo_char_timing.sv
tb/tb_uart_fifo_char_timing.sv
